// ----- design/matrix_vector_transform_defines.svh -----
// Assertion macros used by the top-level design file.
`ifndef MATRIX_VECTOR_TRANSFORM_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_DEFINES_SVH

// Property checked on every rising clk edge outside reset.
`define MVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mvt_pkg.sv -----
package mvt_pkg;

  localparam int DIM      = 3;
  localparam int COEF_W   = 16;
  localparam int COMP_W   = 32;
  localparam int PROD_W   = COEF_W + COMP_W;
  localparam int SUM_W    = PROD_W + $clog2(DIM);
  localparam int FRAC_SH  = 14;
  localparam int ROWS_OUT = (DIM < 3) ? DIM : 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [COMP_W-1:0] comp_t;
  typedef comp_t [DIM-1:0] vec_t;
  typedef coef_t [DIM-1:0] coef_row_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  // Per-stage advance enables, stage 1 = products, 2 = row sum, 3 = output.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

endpackage

// ----- design/mvt_row.sv -----
module mvt_row (
  input  logic                  clk,
  input  mvt_pkg::pipe_ctl_t    ctl,
  input  mvt_pkg::vec_t         vec,
  input  mvt_pkg::coef_row_t    coef_row,
  output mvt_pkg::comp_t        res_r,
  output logic                  sat_r
);

  logic signed [mvt_pkg::PROD_W-1:0] prod_r   [mvt_pkg::DIM];
  logic signed [mvt_pkg::PROD_W-1:0] prod_nxt [mvt_pkg::DIM];
  logic signed [mvt_pkg::SUM_W-1:0]  sum_r;
  logic signed [mvt_pkg::SUM_W-1:0]  sum_nxt;
  logic signed [mvt_pkg::SUM_W-1:0]  shifted;
  logic [mvt_pkg::SUM_W-mvt_pkg::COMP_W:0] hi_bits;
  logic                              ovf;
  mvt_pkg::comp_t                    res_nxt;

  always_comb begin
    for (int j = 0; j < mvt_pkg::DIM; j++) begin
      prod_nxt[j] = mvt_pkg::PROD_W'(vec[j]) * mvt_pkg::PROD_W'(coef_row[j]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < mvt_pkg::DIM; j++) begin
      sum_nxt = sum_nxt + mvt_pkg::SUM_W'(prod_r[j]);
    end
  end

  // Floor shift, then clamp when the result sign and the bits above it disagree.
  always_comb begin
    shifted = sum_r >>> mvt_pkg::FRAC_SH;
    hi_bits = shifted[mvt_pkg::SUM_W-1:mvt_pkg::COMP_W-1];
    ovf     = !((&hi_bits) || !(|hi_bits));
    if (!ovf) begin
      res_nxt = shifted[mvt_pkg::COMP_W-1:0];
    end else if (shifted[mvt_pkg::SUM_W-1]) begin
      res_nxt = {1'b1, {(mvt_pkg::COMP_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(mvt_pkg::COMP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      for (int j = 0; j < mvt_pkg::DIM; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
    end
    if (ctl.en2) begin
      sum_r <= sum_nxt;
    end
    if (ctl.en3) begin
      res_r <= res_nxt;
      sat_r <= ovf;
    end
  end

endmodule

// ----- design/matrix_vector_transform.sv -----
// 3x3 fixed-point vertex transform.
// Input channel (in_valid / in_stall): in_cmd selects a coefficient load or a
// transform. A load writes in_coef (Q1.14) at in_row, in_col of the stored
// matrix and gives no result; a row or column beyond the matrix is dropped.
// A transform multiplies the matrix by in_vec_x/y/z (Q16.16) and gives one
// result on the output channel (out_valid / out_stall): out_x/y/z, each a row
// dot product shifted right by 14 with floor and clamped to 32 bits, and
// out_saturated when any component was clamped.
// A transform passes the product, row sum and shift/clamp stages in that order
// before its result shows on out_x/y/z.
// Throughput: one request per cycle while in_stall is low.
// A transform uses the matrix as it stands when the transform is accepted;
// a load right behind it does not disturb it.
// Reset clears the matrix to zeros and empties the pipeline.
// When out_stall holds a result, earlier stages keep filling their bubbles;
// in_stall rises only once all three stages hold a transform and out_stall is high.
`include "matrix_vector_transform_defines.svh"

module matrix_vector_transform (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [1:0]             in_row,
  input  logic [1:0]             in_col,
  input  logic signed [15:0]     in_coef,
  input  logic signed [31:0]     in_vec_x,
  input  logic signed [31:0]     in_vec_y,
  input  logic signed [31:0]     in_vec_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_x,
  output logic signed [31:0]     out_y,
  output logic signed [31:0]     out_z,
  output logic                   out_saturated
);

  mvt_pkg::coef_t     coef_r [mvt_pkg::DIM][mvt_pkg::DIM];
  mvt_pkg::coef_row_t coef_rows [mvt_pkg::DIM];
  mvt_pkg::vec_t      vec;
  mvt_pkg::pipe_ctl_t ctl;
  mvt_pkg::comp_t     row_res [mvt_pkg::ROWS_OUT];
  logic [mvt_pkg::ROWS_OUT-1:0] row_sat;

  logic v1_r, v2_r, v3_r;
  logic in_acc, load_acc, xform_acc;

  // Each stage advances when empty or when the stage after it advances.
  always_comb begin
    ctl.en3 = !v3_r || !out_stall;
    ctl.en2 = !v2_r || ctl.en3;
    ctl.en1 = !v1_r || ctl.en2;
  end

  assign in_stall  = !ctl.en1;
  assign in_acc    = in_valid && ctl.en1;
  assign load_acc  = in_acc && (in_cmd == mvt_pkg::CMD_LOAD);
  assign xform_acc = in_acc && (in_cmd == mvt_pkg::CMD_XFORM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ctl.en1) begin
        v1_r <= xform_acc;
      end
      if (ctl.en2) begin
        v2_r <= v1_r;
      end
      if (ctl.en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Coefficient store; out-of-range indexes match no entry and are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        for (int c = 0; c < mvt_pkg::DIM; c++) begin
          coef_r[r][c] <= '0;
        end
      end
    end else if (load_acc) begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        for (int c = 0; c < mvt_pkg::DIM; c++) begin
          if (in_row == 2'(r) && in_col == 2'(c)) begin
            coef_r[r][c] <= in_coef;
          end
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        coef_rows[r][c] = coef_r[r][c];
      end
    end
  end

  // Components beyond the third read as zero.
  for (genvar j = 0; j < mvt_pkg::DIM; j++) begin : g_vec
    if (j == 0) begin : g_x
      assign vec[j] = in_vec_x;
    end else if (j == 1) begin : g_y
      assign vec[j] = in_vec_y;
    end else if (j == 2) begin : g_z
      assign vec[j] = in_vec_z;
    end else begin : g_zero
      assign vec[j] = '0;
    end
  end

  for (genvar i = 0; i < mvt_pkg::ROWS_OUT; i++) begin : g_row
    mvt_row u_row (
      .clk      (clk),
      .ctl      (ctl),
      .vec      (vec),
      .coef_row (coef_rows[i]),
      .res_r    (row_res[i]),
      .sat_r    (row_sat[i])
    );
  end

  assign out_valid     = v3_r;
  assign out_x         = row_res[0];
  assign out_saturated = |row_sat;

  if (mvt_pkg::ROWS_OUT > 1) begin : g_out_y
    assign out_y = row_res[1];
  end else begin : g_out_y_zero
    assign out_y = '0;
  end

  if (mvt_pkg::ROWS_OUT > 2) begin : g_out_z
    assign out_z = row_res[2];
  end else begin : g_out_z_zero
    assign out_z = '0;
  end

  `MVT_ASSERT(a_stall_full, !in_stall || (v1_r && v2_r && v3_r && out_stall),
              "input stalled with a bubble in the pipe")
  `MVT_ASSERT_NEXT(a_load_no_item, load_acc, !v1_r, "load entered the result pipeline")
  `MVT_ASSERT_NEXT(a_xform_enters, xform_acc, v1_r, "transform lost at pipeline entry")
  `MVT_ASSERT_NEXT(a_coef_write, load_acc && in_row == 2'd0 && in_col == 2'd0,
                   coef_r[0][0] == $past(in_coef), "coefficient not stored")
  `MVT_ASSERT_NEXT(a_drain, v3_r && !out_stall, !v3_r || $past(v2_r),
                   "result repeated on output")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

typedef struct packed {
  mvt_pkg::comp_t x;
  mvt_pkg::comp_t y;
  mvt_pkg::comp_t z;
  logic           sat;
} vertex_result_t;

class vertex_transform_checker;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  mvt_pkg::coef_t coef_matrix [mvt_pkg::DIM][mvt_pkg::DIM];
  vertex_result_t pending_vertices [$];
  int unsigned    mismatches;
  int unsigned    loads;
  int unsigned    dropped_loads;
  int unsigned    transforms;
  int unsigned    clamped;
  int unsigned    checked;

  function new();
    foreach (coef_matrix[i, j]) coef_matrix[i][j] = '0;
    mismatches = 0;
    loads = 0;
    dropped_loads = 0;
    transforms = 0;
    clamped = 0;
    checked = 0;
  endfunction

  // Update the matrix on a load, or queue the transformed vertex.
  function void note_request(input mvt_pkg::cmd_t cmd, input logic [1:0] row,
                             input logic [1:0] col, input mvt_pkg::coef_t coef,
                             input mvt_pkg::comp_t vx, input mvt_pkg::comp_t vy,
                             input mvt_pkg::comp_t vz);
    mvt_pkg::comp_t vin [3];
    mvt_pkg::comp_t res [3];
    longint         acc;
    longint         q;
    logic           sat;
    vertex_result_t r;
    if (cmd == mvt_pkg::CMD_LOAD) begin
      if (row < mvt_pkg::DIM && col < mvt_pkg::DIM) begin
        coef_matrix[row][col] = coef;
        loads++;
      end else begin
        dropped_loads++;
      end
      return;
    end
    vin[0] = vx;
    vin[1] = vy;
    vin[2] = vz;
    foreach (res[i]) res[i] = '0;
    sat = 1'b0;
    for (int i = 0; i < mvt_pkg::ROWS_OUT; i++) begin
      acc = 0;
      // components beyond the third are zero
      for (int j = 0; j < mvt_pkg::DIM; j++)
        if (j < 3) acc += longint'(coef_matrix[i][j]) * longint'(vin[j]);
      q = acc >>> mvt_pkg::FRAC_SH;
      if (q > SAT_HI) begin
        q = SAT_HI;
        sat = 1'b1;
      end else if (q < SAT_LO) begin
        q = SAT_LO;
        sat = 1'b1;
      end
      res[i] = q[31:0];
    end
    transforms++;
    if (sat) clamped++;
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    r.sat = sat;
    pending_vertices.push_back(r);
  endfunction

  function void check_result(input mvt_pkg::comp_t x, input mvt_pkg::comp_t y,
                             input mvt_pkg::comp_t z, input logic sat);
    vertex_result_t e;
    if (pending_vertices.size() == 0) begin
      $error("result with no transform pending: x=%0d y=%0d z=%0d", x, y, z);
      mismatches++;
      return;
    end
    e = pending_vertices.pop_front();
    checked++;
    if (x !== e.x) begin
      $error("out_x: expected %0d, actual %0d", e.x, x);
      mismatches++;
    end
    if (y !== e.y) begin
      $error("out_y: expected %0d, actual %0d", e.y, y);
      mismatches++;
    end
    if (z !== e.z) begin
      $error("out_z: expected %0d, actual %0d", e.z, z);
      mismatches++;
    end
    if (sat !== e.sat) begin
      $error("out_saturated: expected %0b, actual %0b", e.sat, sat);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  localparam int ITEMS     = 1200;
  localparam int LONG_HOLD = 250;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic           in_cmd;
  logic [1:0]     in_row;
  logic [1:0]     in_col;
  mvt_pkg::coef_t in_coef;
  mvt_pkg::comp_t in_vec_x;
  mvt_pkg::comp_t in_vec_y;
  mvt_pkg::comp_t in_vec_z;
  logic           out_valid;
  logic           out_stall;
  mvt_pkg::comp_t out_x;
  mvt_pkg::comp_t out_y;
  mvt_pkg::comp_t out_z;
  logic           out_saturated;

  vertex_transform_checker xform_check = new();

  int unsigned requests;
  bit          quiet;
  bit          long_hold_req;

  always #5 clk = ~clk;

  matrix_vector_transform u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_coef       (in_coef),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated)
  );

  // All drives are nonblocking, so these see the values that held at the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      xform_check.note_request(mvt_pkg::cmd_t'(in_cmd), in_row, in_col, in_coef,
                               in_vec_x, in_vec_y, in_vec_z);
    if (rst_n && out_valid && !out_stall)
      xform_check.check_result(out_x, out_y, out_z, out_saturated);
  end

  function automatic mvt_pkg::comp_t rand_component();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3, 4, 5: return mvt_pkg::comp_t'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  function automatic mvt_pkg::coef_t rand_coef();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh4000;
      3:       return 16'shC000;
      default: return mvt_pkg::coef_t'($urandom);
    endcase
  endfunction

  task automatic send_request(input mvt_pkg::cmd_t cmd, input logic [1:0] row,
                              input logic [1:0] col, input mvt_pkg::coef_t coef,
                              input mvt_pkg::comp_t vx, input mvt_pkg::comp_t vy,
                              input mvt_pkg::comp_t vz);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_row   <= row;
    in_col   <= col;
    in_coef  <= coef;
    in_vec_x <= vx;
    in_vec_y <= vy;
    in_vec_z <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == mvt_pkg::CMD_XFORM || (row < mvt_pkg::DIM && col < mvt_pkg::DIM)) requests++;
  endtask

  // Vector fields carry noise on a load.
  task automatic load_coef(input logic [1:0] row, input logic [1:0] col,
                           input mvt_pkg::coef_t coef);
    send_request(mvt_pkg::CMD_LOAD, row, col, coef, $urandom, $urandom, $urandom);
  endtask

  // Load fields carry noise on a transform.
  task automatic transform(input mvt_pkg::comp_t vx, input mvt_pkg::comp_t vy,
                           input mvt_pkg::comp_t vz);
    send_request(mvt_pkg::CMD_XFORM, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 mvt_pkg::coef_t'($urandom), vx, vy, vz);
  endtask

  // Result side: random stall bursts, one long hold on request, none when quiet.
  initial begin
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit hold_given;
    int drain;
    hold_given = 1'b0;
    requests = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_cmd   <= mvt_pkg::CMD_LOAD;
    in_row   <= '0;
    in_col   <= '0;
    in_coef  <= '0;
    in_vec_x <= '0;
    in_vec_y <= '0;
    in_vec_z <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Matrix is zero after reset.
    transform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
    // Most negative coefficient everywhere, then clamp high and low.
    for (int r = 0; r < mvt_pkg::DIM; r++)
      for (int c = 0; c < mvt_pkg::DIM; c++)
        load_coef(2'(r), 2'(c), 16'sh8000);
    transform(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    transform(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    // Out-of-range rows and columns must be dropped.
    load_coef(2'd3, 2'd0, 16'sh1234);
    load_coef(2'd0, 2'd3, 16'sh4321);
    load_coef(2'd3, 2'd3, 16'sh7FFF);
    load_coef(2'd2, 2'd2, 16'sh7FFF);
    load_coef(2'd0, 2'd0, 16'sh4000);
    load_coef(2'd1, 2'd1, 16'sh0001);
    // Small odd values exercise floor rounding on negative sums.
    transform(32'sd3, -32'sd5, 32'sh7FFF_FFFF);
    transform(-32'sd1, 32'sd1, -32'sd1);
    transform('0, '0, '0);

    while (requests < ITEMS) begin
      if (!hold_given && requests >= 300) begin
        long_hold_req = 1'b1;
        hold_given = 1'b1;
      end
      if (requests >= ITEMS - 150) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int r = 0; r < mvt_pkg::DIM; r++)
            for (int c = 0; c < mvt_pkg::DIM; c++)
              load_coef(2'(r), 2'(c), rand_coef());
        end
        2, 3: load_coef(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_coef());
        default: begin
          repeat ($urandom_range(1, 8))
            transform(rand_component(), rand_component(), rand_component());
        end
      endcase
    end
    in_valid <= 1'b0;

    drain = 0;
    while (xform_check.pending_vertices.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (xform_check.pending_vertices.size() != 0) begin
      $error("%0d transform results never arrived", xform_check.pending_vertices.size());
      xform_check.mismatches++;
    end

    $display("Coverage: %0d coefficient loads, %0d dropped out-of-range loads, %0d transforms",
             xform_check.loads, xform_check.dropped_loads, xform_check.transforms);
    $display("Coverage: %0d results compared, %0d with clamping, %0d mismatches",
             xform_check.checked, xform_check.clamped, xform_check.mismatches);
    if (xform_check.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/mvt_pkg.sv
design/mvt_row.sv
design/matrix_vector_transform.sv
verif/testbench.sv
